// ===== src/iqdf_pkg.sv =====
package iqdf_pkg;

  localparam int TapsDefault       = 201;
  localparam int SampleBitsDefault = 16;

  localparam int CoefBits  = 16;
  localparam int FracBits  = 15;
  localparam int IndexBits = 8;
  localparam int RatioBits = 5;

  localparam logic [RatioBits-1:0] RatioReset = 5'd5;
  localparam logic [RatioBits-1:0] RatioMax   = 5'd16;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_e;

endpackage

// ===== src/iq_decimating_fir_filter_top.sv =====
// Decimating I/Q FIR filter. Sample items (tuser = 0) enter two TAPS-deep delay
// lines held in one synchronous RAM; coefficient items (tuser = 1) load one
// Q1.15 tap, shared by I and Q, into a second RAM. Every Nth sample item, N
// being the decimation ratio clamped to 1..16, starts a walk over all taps:
// one coefficient and one I/Q pair are read each cycle, multiplied and
// accumulated, and the sums are scaled by 2^-15 (toward zero) and saturated.
// A sample item that gives no result, or a coefficient item, is taken in the
// idle state. An item that gives a result keeps the input side busy through
// the MAC, drain and done states, set by the single read port of each RAM
// (one tap per cycle); done waits while an earlier result is held. The
// result waits in an output register, so the next items are taken while it
// is held. After reset the RAMs are swept to zero before the first item is
// accepted. Write the ratio only while the block is idle.
module iq_decimating_fir_filter_top #(
  parameter int TAPS        = iqdf_pkg::TapsDefault,
  parameter int SAMPLE_BITS = iqdf_pkg::SampleBitsDefault,
  localparam int InW  = ((2 * SAMPLE_BITS + iqdf_pkg::IndexBits + iqdf_pkg::CoefBits + 7) / 8)
                        * 8,
  localparam int OutW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // decimation ratio register
  input  logic                             cfg_we_i,
  input  logic [iqdf_pkg::RatioBits-1:0]   cfg_wdata_i,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [InW-1:0]                   s_axis_tdata,  // i_sample, q_sample, coef_index,
                                                          // coef_value
  input  logic                             s_axis_tuser,  // cmd
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [OutW-1:0]                  m_axis_tdata   // i_out, q_out
);

  localparam int PtrW  = $clog2(TAPS);
  localparam int CW    = iqdf_pkg::CoefBits;
  localparam int ProdW = SAMPLE_BITS + CW;
  localparam int AccW  = ProdW + $clog2(TAPS);
  localparam int DlW   = 2 * SAMPLE_BITS;
  localparam logic [PtrW-1:0] LastTap = PtrW'(TAPS - 1);
  localparam logic signed [AccW-1:0] SatHi = AccW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);
  localparam logic signed [AccW-1:0] RndBias = AccW'((64'sd1 <<< iqdf_pkg::FracBits) - 64'sd1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [iqdf_pkg::RatioBits-1:0] ratio_q, ratio_eff;
  logic [iqdf_pkg::RatioBits-1:0] phase_q, phase_d, phase_inc;
  logic [PtrW-1:0] wp_q, wp_d, wp_next;
  logic [PtrW-1:0] tap_q, tap_d;
  logic [PtrW-1:0] pos_q, pos_d;

  // input unpacking
  logic signed [SAMPLE_BITS-1:0] in_i, in_q;
  logic [iqdf_pkg::IndexBits-1:0] in_idx;
  logic [CW-1:0] in_coef;
  logic          in_fire, is_coef, due, coef_ok;

  assign in_i    = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign in_q    = $signed(s_axis_tdata[DlW-1:SAMPLE_BITS]);
  assign in_idx  = s_axis_tdata[DlW+iqdf_pkg::IndexBits-1:DlW];
  assign in_coef = s_axis_tdata[DlW+iqdf_pkg::IndexBits+CW-1:DlW+iqdf_pkg::IndexBits];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign is_coef = (iqdf_pkg::cmd_e'(s_axis_tuser) == iqdf_pkg::CMD_COEF);
  assign coef_ok = (32'(in_idx) < TAPS);

  // ratio 0 acts as 1, anything above 16 as 16
  always_comb begin
    if (ratio_q == '0) begin
      ratio_eff = iqdf_pkg::RatioBits'(1);
    end else if (ratio_q > iqdf_pkg::RatioMax) begin
      ratio_eff = iqdf_pkg::RatioMax;
    end else begin
      ratio_eff = ratio_q;
    end
  end

  assign phase_inc = phase_q + iqdf_pkg::RatioBits'(1);
  assign due       = (phase_inc >= ratio_eff);
  assign wp_next   = (wp_q == LastTap) ? '0 : wp_q + PtrW'(1);

  // MAC pipeline: RAM read -> multiply -> accumulate
  logic                  issue;
  logic                  rd_vld_q, prod_vld_q;
  logic [CW-1:0]         coef_rd_q;
  logic [DlW-1:0]        dl_rd_q;
  logic signed [ProdW-1:0] prod_i_d, prod_q_d, prod_i_q, prod_q_q;
  logic signed [AccW-1:0]  acc_i_q, acc_q_q;

  // result path
  logic                  load_out, out_vld_q;
  logic [SAMPLE_BITS-1:0] res_i, res_q, out_i_q, out_q_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    wp_d    = wp_q;
    tap_d   = tap_q;
    pos_d   = pos_q;
    issue   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        tap_d = (tap_q == LastTap) ? '0 : tap_q + PtrW'(1);
        if (tap_q == LastTap) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && !is_coef) begin
          wp_d = wp_next;
          if (due) begin
            phase_d = '0;
            tap_d   = '0;
            pos_d   = wp_next;  // oldest sample sits at the new write slot
            state_d = ST_MAC;
          end else begin
            phase_d = phase_inc;
          end
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        tap_d = (tap_q == LastTap) ? '0 : tap_q + PtrW'(1);
        pos_d = (pos_q == LastTap) ? '0 : pos_q + PtrW'(1);
        if (tap_q == LastTap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ratio_q    <= iqdf_pkg::RatioReset;
      phase_q    <= '0;
      wp_q       <= '0;
      tap_q      <= '0;
      pos_q      <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      wp_q       <= wp_d;
      tap_q      <= tap_d;
      pos_q      <= pos_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // coefficient RAM
  logic [CW-1:0] coef_mem [TAPS];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      coef_mem[tap_q] <= '0;
    end else if (in_fire && is_coef && coef_ok) begin
      coef_mem[PtrW'(in_idx)] <= in_coef;
    end
    if (issue) begin
      coef_rd_q <= coef_mem[tap_q];
    end
  end

  // delay-line RAM, Q in the upper half of each word
  logic [DlW-1:0] dl_mem [TAPS];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      dl_mem[tap_q] <= '0;
    end else if (in_fire && !is_coef) begin
      dl_mem[wp_q] <= {in_q, in_i};
    end
    if (issue) begin
      dl_rd_q <= dl_mem[pos_q];
    end
  end

  assign prod_i_d = $signed(dl_rd_q[SAMPLE_BITS-1:0]) * $signed(coef_rd_q);
  assign prod_q_d = $signed(dl_rd_q[DlW-1:SAMPLE_BITS]) * $signed(coef_rd_q);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_i_q <= prod_i_d;
      prod_q_q <= prod_q_d;
    end
    if (in_fire) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (prod_vld_q) begin
      acc_i_q <= acc_i_q + {{(AccW-ProdW){prod_i_q[ProdW-1]}}, prod_i_q};
      acc_q_q <= acc_q_q + {{(AccW-ProdW){prod_q_q[ProdW-1]}}, prod_q_q};
    end
  end

  // scale by 2^-15 toward zero, then clamp
  function automatic logic [SAMPLE_BITS-1:0] scale_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] biased;
    logic signed [AccW-1:0] quo;
    biased = acc + (acc[AccW-1] ? RndBias : '0);
    quo    = biased >>> iqdf_pkg::FracBits;
    if (quo > SatHi) begin
      quo = SatHi;
    end else if (quo < SatLo) begin
      quo = SatLo;
    end
    return quo[SAMPLE_BITS-1:0];
  endfunction

  assign res_i = scale_sat(acc_i_q);
  assign res_q = scale_sat(acc_q_q);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_i_q <= res_i;
      out_q_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({out_q_q, out_i_q});

  // the phase counter never reaches the largest ratio
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < iqdf_pkg::RatioMax)
    else $error("phase counter out of range");

  // a completed phase starts the tap walk at the oldest sample
  a_mac_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_coef && due) |=> (state_q == ST_MAC && tap_q == '0 && pos_q == wp_q))
    else $error("tap walk did not start at the oldest sample");

  // the walk covers every tap and ends back at the write slot
  a_walk_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DRAIN) |-> (tap_q == '0 && pos_q == wp_q))
    else $error("tap walk incomplete");

  // a held result is never overwritten
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_vld_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("pending result overwritten");

  // RAM pointers stay inside the tap range
  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wp_q) < TAPS) && (32'(pos_q) < TAPS) && (32'(tap_q) < TAPS))
    else $error("RAM pointer out of range");

endmodule
